>>> design/wrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrp_pkg
// Shared types and constants for the WAV RIFF header parser.
// ----------------------------------------------------------------------------
package wrp_pkg;

    // Item kinds on the input channel.
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_EOF     = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // Error codes of a result.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_TAGS  = 3'd1;
    localparam logic [2:0] ERR_SHORT_FMT = 3'd2;
    localparam logic [2:0] ERR_NO_FMT    = 3'd3;
    localparam logic [2:0] ERR_LIMIT     = 3'd4;
    localparam logic [2:0] ERR_TRUNCATED = 3'd5;

    // Big-endian views of the four-character tags as they shift in.
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] FMT_BODY_LEN        = 32'd16;
    localparam logic [3:0]  RIFF_HDR_LAST       = 4'd11;
    localparam logic [7:0]  DEFAULT_CHUNK_LIMIT = 8'd32;

    typedef struct packed {
        logic        valid;
        logic        ok;
        logic [2:0]  error_code;
        logic [31:0] sample_rate;
        logic [15:0] channel_count;
        logic [15:0] sample_bits;
        logic [31:0] data_length;
        logic [31:0] data_offset;
    } t_result;

endpackage

>>> design/wrp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrp_in_if
// Input channel of the parser: one file byte, end of file or restart per item.
// ----------------------------------------------------------------------------
interface wrp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink (input valid, input kind, input data_byte, output ready);
endinterface

>>> design/wrp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrp_out_if
// Result channel of the parser: success or failure with the header fields.
// ----------------------------------------------------------------------------
interface wrp_out_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [2:0]  error_code;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [15:0] sample_bits;
    logic [31:0] data_length;
    logic [31:0] data_offset;

    modport source (
        output valid, output ok, output error_code, output sample_rate,
        output channel_count, output sample_bits, output data_length,
        output data_offset, input ready
    );
    modport sink (
        input valid, input ok, input error_code, input sample_rate,
        input channel_count, input sample_bits, input data_length,
        input data_offset, output ready
    );
endinterface

>>> design/wrp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrp_core
// Parse state machine: walks the RIFF header, chunk headers and chunk bodies one byte per
// accepted item and produces at most one result per item.
// ----------------------------------------------------------------------------
module wrp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [1:0]       i_kind,
    input  logic [7:0]       i_data_byte,
    input  logic [7:0]       i_chunk_limit,
    output wrp_pkg::t_result o_res
);

    localparam logic [1:0] PH_RIFF  = 2'd0;
    localparam logic [1:0] PH_CHUNK = 2'd1;
    localparam logic [1:0] PH_FMT   = 2'd2;
    localparam logic [1:0] PH_SKIP  = 2'd3;

    // Control state.
    logic [1:0]  r_phase, n_phase;
    logic [31:0] r_byte_pos, n_byte_pos;
    logic [3:0]  r_fcnt, n_fcnt;
    logic [7:0]  r_chunks_seen, n_chunks_seen;
    logic        r_fmt_seen, n_fmt_seen;
    logic        r_finished, n_finished;
    logic        r_tags_bad, n_tags_bad;

    // Data state; always fully written before it is used.
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_chunk_len, n_chunk_len;
    logic [32:0] r_skip, n_skip;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_channels, n_channels;
    logic [15:0] r_bits, n_bits;

    logic [7:0]  chunks_inc;
    logic [31:0] tag_shifted;
    logic [31:0] len_merged;
    logic [32:0] skip_odd;
    logic [32:0] skip_fmt;
    wrp_pkg::t_result res;

    assign chunks_inc  = (r_chunks_seen == 8'hFF) ? r_chunks_seen : r_chunks_seen + 8'd1;
    assign tag_shifted = {r_tag[23:0], i_data_byte};
    assign skip_odd    = {1'b0, len_merged} + {32'd0, len_merged[0]};
    assign skip_fmt    = {1'b0, r_chunk_len - wrp_pkg::FMT_BODY_LEN};

    // Length bytes arrive little-endian at header positions four to seven.
    always_comb begin
        len_merged = r_chunk_len;
        case (r_fcnt[1:0])
            2'd0:    len_merged[7:0]   = i_data_byte;
            2'd1:    len_merged[15:8]  = i_data_byte;
            2'd2:    len_merged[23:16] = i_data_byte;
            default: len_merged[31:24] = i_data_byte;
        endcase
    end

    always_comb begin
        n_phase       = r_phase;
        n_byte_pos    = r_byte_pos;
        n_fcnt        = r_fcnt;
        n_chunks_seen = r_chunks_seen;
        n_fmt_seen    = r_fmt_seen;
        n_finished    = r_finished;
        n_tags_bad    = r_tags_bad;
        n_tag         = r_tag;
        n_chunk_len   = r_chunk_len;
        n_skip        = r_skip;
        n_rate        = r_rate;
        n_channels    = r_channels;
        n_bits        = r_bits;
        res           = '0;

        if (i_step) begin
            unique case (i_kind)
                wrp_pkg::KIND_RESTART: begin
                    n_phase       = PH_RIFF;
                    n_byte_pos    = '0;
                    n_fcnt        = '0;
                    n_chunks_seen = '0;
                    n_fmt_seen    = 1'b0;
                    n_finished    = 1'b0;
                    n_tags_bad    = 1'b0;
                end
                wrp_pkg::KIND_EOF: begin
                    if (!r_finished) begin
                        res.valid      = 1'b1;
                        res.error_code = wrp_pkg::ERR_TRUNCATED;
                        n_finished     = 1'b1;
                    end
                end
                wrp_pkg::KIND_BYTE: begin
                    if (!r_finished) begin
                        n_byte_pos = r_byte_pos + 32'd1;
                        n_fcnt     = r_fcnt + 4'd1;
                        unique case (r_phase)
                            PH_RIFF: begin
                                // The middle four bytes (the RIFF size) do not shift in.
                                if (r_fcnt < 4'd4 || r_fcnt >= 4'd8) begin
                                    n_tag = tag_shifted;
                                end
                                if (r_fcnt == 4'd3 && tag_shifted != wrp_pkg::TAG_RIFF) begin
                                    n_tags_bad = 1'b1;
                                end
                                if (r_fcnt >= wrp_pkg::RIFF_HDR_LAST) begin
                                    if (r_tags_bad || tag_shifted != wrp_pkg::TAG_WAVE) begin
                                        res.valid      = 1'b1;
                                        res.error_code = wrp_pkg::ERR_BAD_TAGS;
                                        n_finished     = 1'b1;
                                    end else if (r_chunks_seen >= i_chunk_limit) begin
                                        res.valid      = 1'b1;
                                        res.error_code = wrp_pkg::ERR_LIMIT;
                                        n_finished     = 1'b1;
                                    end else begin
                                        n_phase = PH_CHUNK;
                                        n_fcnt  = '0;
                                    end
                                end
                            end
                            PH_CHUNK: begin
                                if (r_fcnt < 4'd4) begin
                                    n_tag = tag_shifted;
                                end else begin
                                    n_chunk_len = len_merged;
                                end
                                if (r_fcnt >= 4'd7) begin
                                    n_chunks_seen = chunks_inc;
                                    if (r_tag == wrp_pkg::TAG_FMT) begin
                                        if (len_merged < wrp_pkg::FMT_BODY_LEN) begin
                                            res.valid      = 1'b1;
                                            res.error_code = wrp_pkg::ERR_SHORT_FMT;
                                            n_finished     = 1'b1;
                                        end else begin
                                            n_phase = PH_FMT;
                                            n_fcnt  = '0;
                                        end
                                    end else if (r_tag == wrp_pkg::TAG_DATA) begin
                                        res.valid = 1'b1;
                                        n_finished = 1'b1;
                                        if (!r_fmt_seen) begin
                                            res.error_code = wrp_pkg::ERR_NO_FMT;
                                        end else begin
                                            res.ok            = 1'b1;
                                            res.error_code    = wrp_pkg::ERR_NONE;
                                            res.sample_rate   = r_rate;
                                            res.channel_count = r_channels;
                                            res.sample_bits   = r_bits;
                                            res.data_length   = len_merged;
                                            res.data_offset   = n_byte_pos;
                                        end
                                    end else if (skip_odd == '0) begin
                                        // The limit is judged with this header counted.
                                        if (chunks_inc >= i_chunk_limit) begin
                                            res.valid      = 1'b1;
                                            res.error_code = wrp_pkg::ERR_LIMIT;
                                            n_finished     = 1'b1;
                                        end else begin
                                            n_phase = PH_CHUNK;
                                            n_fcnt  = '0;
                                        end
                                    end else begin
                                        n_skip  = skip_odd;
                                        n_phase = PH_SKIP;
                                    end
                                end
                            end
                            PH_FMT: begin
                                case (r_fcnt)
                                    4'd2:    n_channels[7:0]  = i_data_byte;
                                    4'd3:    n_channels[15:8] = i_data_byte;
                                    4'd4:    n_rate[7:0]      = i_data_byte;
                                    4'd5:    n_rate[15:8]     = i_data_byte;
                                    4'd6:    n_rate[23:16]    = i_data_byte;
                                    4'd7:    n_rate[31:24]    = i_data_byte;
                                    4'd14:   n_bits[7:0]      = i_data_byte;
                                    4'd15:   n_bits[15:8]     = i_data_byte;
                                    default: ;
                                endcase
                                if (r_fcnt == 4'd15) begin
                                    n_fmt_seen = 1'b1;
                                    if (skip_fmt == '0) begin
                                        if (r_chunks_seen >= i_chunk_limit) begin
                                            res.valid      = 1'b1;
                                            res.error_code = wrp_pkg::ERR_LIMIT;
                                            n_finished     = 1'b1;
                                        end else begin
                                            n_phase = PH_CHUNK;
                                            n_fcnt  = '0;
                                        end
                                    end else begin
                                        n_skip  = skip_fmt;
                                        n_phase = PH_SKIP;
                                    end
                                end
                            end
                            default: begin
                                n_skip = r_skip - 33'd1;
                                if (r_skip <= 33'd1) begin
                                    if (r_chunks_seen >= i_chunk_limit) begin
                                        res.valid      = 1'b1;
                                        res.error_code = wrp_pkg::ERR_LIMIT;
                                        n_finished     = 1'b1;
                                    end else begin
                                        n_phase = PH_CHUNK;
                                        n_fcnt  = '0;
                                    end
                                end
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_RIFF;
            r_byte_pos    <= '0;
            r_fcnt        <= '0;
            r_chunks_seen <= '0;
            r_fmt_seen    <= 1'b0;
            r_finished    <= 1'b0;
            r_tags_bad    <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_byte_pos    <= n_byte_pos;
            r_fcnt        <= n_fcnt;
            r_chunks_seen <= n_chunks_seen;
            r_fmt_seen    <= n_fmt_seen;
            r_finished    <= n_finished;
            r_tags_bad    <= n_tags_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag       <= n_tag;
        r_chunk_len <= n_chunk_len;
        r_skip      <= n_skip;
        r_rate      <= n_rate;
        r_channels  <= n_channels;
        r_bits      <= n_bits;
    end

    // A running skip always has bytes left to consume.
    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP && !r_finished) |-> (r_skip != '0))
        else $error("skip phase entered with nothing to skip");

    // Once a result has gone out, only a restart may change anything.
    a_quiet_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_finished && i_kind != wrp_pkg::KIND_RESTART) |-> !res.valid)
        else $error("result produced after the parse had finished");

    // Success requires a complete fmt chunk earlier in the file.
    a_ok_needs_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.valid && res.ok) |-> r_fmt_seen)
        else $error("success reported without a fmt chunk");

endmodule

>>> design/wav_riff_header_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_riff_header_parser_unit
// Streaming WAV header parser with a one-deep result register.
// A result appears in the cycle after the item that completes it.
// Throughput: one item per cycle; the byte step and the result register
// overlap, so input stalls only while a waiting result is not taken.
// Reset: synchronous, active low; clears the parse state and the result
// register and sets chunk_limit to 32.
// ----------------------------------------------------------------------------
module wav_riff_header_parser_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wrp_in_if.sink     i_in_ch,
    wrp_out_if.source  o_out_ch,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    logic             r_chunk_limit_valid;
    logic [7:0]       r_chunk_limit;
    wrp_pkg::t_result r_out, n_out;
    wrp_pkg::t_result core_res;
    logic             in_fire;
    logic             out_fire;

    assign in_fire        = i_in_ch.valid && i_in_ch.ready;
    assign out_fire       = r_out.valid && o_out_ch.ready;
    assign i_in_ch.ready  = !r_out.valid || o_out_ch.ready;

    wrp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (in_fire),
        .i_kind        (i_in_ch.kind),
        .i_data_byte   (i_in_ch.data_byte),
        .i_chunk_limit (r_chunk_limit),
        .o_res         (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_limit       <= wrp_pkg::DEFAULT_CHUNK_LIMIT;
            r_chunk_limit_valid <= 1'b1;
        end else if (i_cfg_we) begin
            r_chunk_limit       <= i_cfg_wdata;
            r_chunk_limit_valid <= 1'b1;
        end
    end

    // A new item may replace the result only when the old one leaves now.
    always_comb begin
        n_out = r_out;
        if (out_fire) begin
            n_out.valid = 1'b0;
        end
        if (in_fire) begin
            n_out = core_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out <= n_out;
        end
    end

    assign o_out_ch.valid         = r_out.valid;
    assign o_out_ch.ok            = r_out.ok;
    assign o_out_ch.error_code    = r_out.error_code;
    assign o_out_ch.sample_rate   = r_out.sample_rate;
    assign o_out_ch.channel_count = r_out.channel_count;
    assign o_out_ch.sample_bits   = r_out.sample_bits;
    assign o_out_ch.data_length   = r_out.data_length;
    assign o_out_ch.data_offset   = r_out.data_offset;

    a_ok_code_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out.valid && r_out.ok) |-> (r_out.error_code == wrp_pkg::ERR_NONE))
        else $error("successful result carries an error code");

    a_fail_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out.valid && !r_out.ok) |-> (r_out.error_code != wrp_pkg::ERR_NONE
            && r_out.sample_rate == '0 && r_out.data_length == '0
            && r_out.data_offset == '0))
        else $error("failed result has data fields or no error code");

    a_limit_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_chunk_limit_valid && r_chunk_limit == $past(i_cfg_wdata)))
        else $error("chunk limit write was lost");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for wav_riff_header_parser_unit. WAV files are
// streamed in one byte per item: well-formed headers with random
// content, mixed with bad tags, short fmt chunks, missing fmt chunks, chunk
// limit overruns, truncated files and noise. A scoreboard class keeps its own
// copy of the parse state, predicts every result and checks each result the
// block delivers. Both channels stall at random while the chunk limit is
// moved through several settings between files.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT    = 600000;
    localparam int ITEMS_PER_STEP = 140;
    localparam int NUM_STEPS      = 6;

    typedef enum logic [1:0] {
        PARSE_RIFF,
        PARSE_CHUNK,
        PARSE_FMT,
        PARSE_SKIP
    } t_parse_phase;

    // Predicts the parser and checks its results in order.
    class header_scoreboard;
        logic [7:0]        chunk_limit;
        t_parse_phase      phase;
        logic [31:0]       byte_pos;
        logic [3:0]        field_cnt;
        logic [31:0]       tag_reg;
        logic [31:0]       chunk_len;
        logic [32:0]       skip_left;
        logic [7:0]        chunks_seen;
        bit                fmt_seen;
        bit                parse_done;
        bit                tags_bad;
        logic [31:0]       rate;
        logic [15:0]       channels;
        logic [15:0]       sample_width;
        wrp_pkg::t_result  expected_results[$];
        int                mismatches;
        int                results_seen;
        int                headers_ok;

        function new();
            chunk_limit  = wrp_pkg::DEFAULT_CHUNK_LIMIT;
            mismatches   = 0;
            results_seen = 0;
            headers_ok   = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            phase        = PARSE_RIFF;
            byte_pos     = '0;
            field_cnt    = '0;
            tag_reg      = '0;
            chunk_len    = '0;
            skip_left    = '0;
            chunks_seen  = '0;
            fmt_seen     = 1'b0;
            parse_done   = 1'b0;
            tags_bad     = 1'b0;
            rate         = '0;
            channels     = '0;
            sample_width = '0;
        endfunction

        function void post_failure(logic [2:0] code);
            wrp_pkg::t_result r;
            r            = '0;
            r.valid      = 1'b1;
            r.error_code = code;
            expected_results.push_back(r);
            parse_done = 1'b1;
        endfunction

        // A new chunk header may start only while the limit allows it.
        function void open_chunk();
            if (chunks_seen >= chunk_limit) begin
                post_failure(wrp_pkg::ERR_LIMIT);
            end else begin
                phase     = PARSE_CHUNK;
                field_cnt = '0;
            end
        endfunction

        function void open_skip(logic [32:0] count);
            if (count == '0) begin
                open_chunk();
            end else begin
                skip_left = count;
                phase     = PARSE_SKIP;
            end
        endfunction

        function void close_header();
            wrp_pkg::t_result r;
            if (chunks_seen < 8'd255) begin
                chunks_seen++;
            end
            if (tag_reg == wrp_pkg::TAG_FMT) begin
                if (chunk_len < wrp_pkg::FMT_BODY_LEN) begin
                    post_failure(wrp_pkg::ERR_SHORT_FMT);
                end else begin
                    phase     = PARSE_FMT;
                    field_cnt = '0;
                end
            end else if (tag_reg == wrp_pkg::TAG_DATA) begin
                if (!fmt_seen) begin
                    post_failure(wrp_pkg::ERR_NO_FMT);
                end else begin
                    r               = '0;
                    r.valid         = 1'b1;
                    r.ok            = 1'b1;
                    r.error_code    = wrp_pkg::ERR_NONE;
                    r.sample_rate   = rate;
                    r.channel_count = channels;
                    r.sample_bits   = sample_width;
                    r.data_length   = chunk_len;
                    r.data_offset   = byte_pos;
                    expected_results.push_back(r);
                    parse_done = 1'b1;
                end
            end else begin
                // Other chunks carry a pad byte when their length is odd.
                open_skip({1'b0, chunk_len} + {32'd0, chunk_len[0]});
            end
        endfunction

        function void take_byte(logic [7:0] b);
            int n;
            n = field_cnt;
            byte_pos++;
            case (phase)
                PARSE_RIFF: begin
                    if (n < 4 || n >= 8) begin
                        tag_reg = {tag_reg[23:0], b};
                    end
                    field_cnt = field_cnt + 4'd1;
                    if (n == 3 && tag_reg != wrp_pkg::TAG_RIFF) begin
                        tags_bad = 1'b1;
                    end
                    if (n + 1 >= 12) begin
                        if (tags_bad || tag_reg != wrp_pkg::TAG_WAVE) begin
                            post_failure(wrp_pkg::ERR_BAD_TAGS);
                        end else begin
                            open_chunk();
                        end
                    end
                end
                PARSE_CHUNK: begin
                    if (n < 4) begin
                        tag_reg = {tag_reg[23:0], b};
                    end else begin
                        chunk_len[(n - 4) * 8 +: 8] = b;
                    end
                    field_cnt = field_cnt + 4'd1;
                    if (n + 1 >= 8) begin
                        close_header();
                    end
                end
                PARSE_FMT: begin
                    if (n == 2) begin
                        channels[7:0] = b;
                    end else if (n == 3) begin
                        channels[15:8] = b;
                    end else if (n >= 4 && n <= 7) begin
                        rate[(n - 4) * 8 +: 8] = b;
                    end else if (n == 14) begin
                        sample_width[7:0] = b;
                    end else if (n == 15) begin
                        sample_width[15:8] = b;
                    end
                    field_cnt = field_cnt + 4'd1;
                    if (n + 1 >= 16) begin
                        // The tail of a fmt chunk is skipped without a pad byte.
                        fmt_seen = 1'b1;
                        open_skip({1'b0, chunk_len - wrp_pkg::FMT_BODY_LEN});
                    end
                end
                default: begin
                    if (skip_left != '0) begin
                        skip_left--;
                    end
                    if (skip_left == '0) begin
                        open_chunk();
                    end
                end
            endcase
        endfunction

        function void note_item(logic [1:0] kind, logic [7:0] b);
            if (kind == wrp_pkg::KIND_RESTART) begin
                clear_parse();
            end else if (!parse_done) begin
                if (kind == wrp_pkg::KIND_EOF) begin
                    post_failure(wrp_pkg::ERR_TRUNCATED);
                end else if (kind == wrp_pkg::KIND_BYTE) begin
                    take_byte(b);
                end
            end
        endfunction

        function void field_check(string name, logic [31:0] want, logic [31:0] seen);
            if (seen !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d: %s expected %0h, got %0h",
                             results_seen, name, want, seen);
                end
            end
        endfunction

        function void check_result(wrp_pkg::t_result got);
            wrp_pkg::t_result want;
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d: unexpected result, ok %0b code %0d",
                             results_seen, got.ok, got.error_code);
                end
                return;
            end
            want = expected_results.pop_front();
            if (want.ok) begin
                headers_ok++;
            end
            field_check("ok", want.ok, got.ok);
            field_check("error_code", want.error_code, got.error_code);
            field_check("sample_rate", want.sample_rate, got.sample_rate);
            field_check("channel_count", want.channel_count, got.channel_count);
            field_check("sample_bits", want.sample_bits, got.sample_bits);
            field_check("data_length", want.data_length, got.data_length);
            field_check("data_offset", want.data_offset, got.data_offset);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function int total_failures();
            return mismatches + expected_results.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;

    wrp_in_if  in_ch ();
    wrp_out_if out_ch ();

    wav_riff_header_parser_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    header_scoreboard board = new();

    logic [7:0] file_q[$];
    int         src_idle_pct  = 0;
    int         sink_stall_pct = 0;
    int         items_sent    = 0;
    int         files_sent    = 0;
    int         limits_used   = 1;
    int         cycle_count   = 0;

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: take results and stall in random bursts.
    initial begin : result_sink
        int               stall_left;
        wrp_pkg::t_result got;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got.valid         = 1'b1;
                got.ok            = out_ch.ok;
                got.error_code    = out_ch.error_code;
                got.sample_rate   = out_ch.sample_rate;
                got.channel_count = out_ch.channel_count;
                got.sample_bits   = out_ch.sample_bits;
                got.data_length   = out_ch.data_length;
                got.data_offset   = out_ch.data_offset;
                board.check_result(got);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
                stall_left = $urandom_range(1, 18) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic [7:0] b);
        int gap;
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            gap = $urandom_range(1, 18);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind;
        in_ch.data_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        board.note_item(kind, b);
        items_sent++;
    endtask

    task automatic stream_file();
        for (int i = 0; i < file_q.size(); i++) begin
            send_item(wrp_pkg::KIND_BYTE, file_q[i]);
        end
        file_q.delete();
    endtask

    // Hold the input off until every predicted result has been taken.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_chunk_limit(input logic [7:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        board.chunk_limit = value;
        i_cfg_we <= 1'b0;
        limits_used++;
    endtask

    function automatic void push_tag(logic [31:0] tag);
        for (int i = 3; i >= 0; i--) begin
            file_q.push_back(tag[i * 8 +: 8]);
        end
    endfunction

    function automatic void push_le32(logic [31:0] v);
        for (int i = 0; i < 4; i++) begin
            file_q.push_back(v[i * 8 +: 8]);
        end
    endfunction

    function automatic void push_random(int count);
        for (int i = 0; i < count; i++) begin
            file_q.push_back(8'($urandom));
        end
    endfunction

    function automatic void push_riff_header();
        push_tag(wrp_pkg::TAG_RIFF);
        push_le32($urandom);
        push_tag(wrp_pkg::TAG_WAVE);
    endfunction

    function automatic logic [31:0] other_tag();
        logic [31:0] t;
        t = ($urandom_range(0, 3) == 0) ? 32'h4C49_5354 : $urandom;
        if (t == wrp_pkg::TAG_FMT || t == wrp_pkg::TAG_DATA) begin
            t[0] = ~t[0];
        end
        return t;
    endfunction

    function automatic void push_other_chunk(logic [31:0] len);
        push_tag(other_tag());
        push_le32(len);
        push_random(len + len[0]);
    endfunction

    function automatic void push_fmt_chunk(logic [31:0] len);
        push_tag(wrp_pkg::TAG_FMT);
        push_le32(len);
        push_random(len);
    endfunction

    function automatic void push_data_header();
        logic [31:0] len;
        case ($urandom_range(0, 5))
            0:       len = 32'h0000_0000;
            1:       len = 32'hFFFF_FFFF;
            default: len = $urandom;
        endcase
        push_tag(wrp_pkg::TAG_DATA);
        push_le32(len);
    endfunction

    function automatic void push_good_file();
        push_riff_header();
        repeat ($urandom_range(0, 2)) push_other_chunk($urandom_range(0, 9));
        push_fmt_chunk($urandom_range(16, 21));
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(0, 1)) push_other_chunk($urandom_range(0, 5));
            push_fmt_chunk($urandom_range(16, 19));
        end
        repeat ($urandom_range(0, 1)) push_other_chunk($urandom_range(0, 7));
        push_data_header();
    endfunction

    task automatic run_one_file(input bit quiet_mode);
        int          pick;
        int          cut;
        int          pos;
        logic [31:0] big_len;
        if (quiet_mode) begin
            src_idle_pct   = 0;
            sink_stall_pct = 0;
        end else begin
            src_idle_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
            sink_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        end
        files_sent++;
        send_item(wrp_pkg::KIND_RESTART, 8'($urandom));
        file_q.delete();
        pick = $urandom_range(0, 99);
        if (pick < 48) begin
            push_good_file();
            // Bytes and end of file after the result are ignored.
            push_random($urandom_range(0, 3));
            stream_file();
            if ($urandom_range(0, 3) == 0) begin
                send_item(wrp_pkg::KIND_EOF, 8'($urandom));
            end
        end else if (pick < 56) begin
            push_riff_header();
            pos = $urandom_range(0, 7);
            if (pos >= 4) begin
                pos = pos + 4;
            end
            file_q[pos] = file_q[pos] ^ 8'($urandom_range(1, 255));
            push_random($urandom_range(0, 4));
            stream_file();
        end else if (pick < 62) begin
            push_riff_header();
            repeat ($urandom_range(0, 1)) push_other_chunk($urandom_range(0, 5));
            push_tag(wrp_pkg::TAG_FMT);
            push_le32($urandom_range(0, 15));
            push_random($urandom_range(0, 3));
            stream_file();
        end else if (pick < 68) begin
            push_riff_header();
            repeat ($urandom_range(0, 2)) push_other_chunk($urandom_range(0, 6));
            push_data_header();
            stream_file();
        end else if (pick < 76 && board.chunk_limit <= 16) begin
            push_riff_header();
            for (int i = 0; i < board.chunk_limit; i++) begin
                if ($urandom_range(0, 2) == 0) begin
                    push_fmt_chunk($urandom_range(16, 19));
                end else begin
                    push_other_chunk($urandom_range(0, 5));
                end
            end
            push_tag(other_tag());
            push_le32($urandom_range(0, 5));
            stream_file();
        end else if (pick < 88) begin
            push_good_file();
            cut = $urandom_range(0, file_q.size() - 1);
            while (file_q.size() > cut) begin
                void'(file_q.pop_back());
            end
            stream_file();
            // Without the end of file, the next restart cuts the parse short.
            if ($urandom_range(0, 3) != 0) begin
                send_item(wrp_pkg::KIND_EOF, 8'($urandom));
            end
        end else if (pick < 94) begin
            // Huge chunk lengths are walked byte by byte, so end the file early.
            push_riff_header();
            big_len = $urandom | 32'h0000_1000;
            if ($urandom_range(0, 1) == 0) begin
                push_tag(other_tag());
                push_le32(big_len);
                push_random($urandom_range(0, 20));
            end else begin
                push_tag(wrp_pkg::TAG_FMT);
                push_le32(big_len);
                push_random($urandom_range(16, 30));
            end
            stream_file();
            send_item(wrp_pkg::KIND_EOF, 8'($urandom));
        end else begin
            if ($urandom_range(0, 1) == 0) begin
                push_riff_header();
            end
            push_random($urandom_range(1, 24));
            stream_file();
            if ($urandom_range(0, 4) != 0) begin
                send_item(wrp_pkg::KIND_EOF, 8'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        logic [7:0] limit_plan[NUM_STEPS];
        int         step_items;
        int         step_results;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.kind      <= wrp_pkg::KIND_BYTE;
        in_ch.data_byte <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: end of file on an empty parse, ignored items after a
        // result, bad tags with extreme bytes, and truncation before the tags
        // are judged.
        send_item(wrp_pkg::KIND_EOF, 8'h00);
        send_item(wrp_pkg::KIND_BYTE, 8'hFF);
        send_item(wrp_pkg::KIND_EOF, 8'hFF);
        send_item(wrp_pkg::KIND_RESTART, 8'h00);
        push_tag(wrp_pkg::TAG_RIFF);
        push_le32(32'h00FF_00FF);
        push_tag({wrp_pkg::TAG_WAVE[31:8], 8'h58});
        stream_file();
        send_item(wrp_pkg::KIND_RESTART, 8'hFF);
        push_tag(wrp_pkg::TAG_RIFF);
        stream_file();
        send_item(wrp_pkg::KIND_EOF, 8'h00);

        limit_plan[0] = wrp_pkg::DEFAULT_CHUNK_LIMIT;
        limit_plan[1] = 8'd1;
        limit_plan[2] = 8'd255;
        limit_plan[3] = 8'($urandom_range(2, 8));
        limit_plan[4] = 8'($urandom_range(9, 40));
        limit_plan[5] = 8'd3;

        for (int s = 0; s < NUM_STEPS; s++) begin
            if (s > 0) begin
                set_chunk_limit(limit_plan[s]);
            end
            step_items   = items_sent;
            step_results = board.results_seen;
            while (items_sent - step_items < ITEMS_PER_STEP
                   || board.results_seen - step_results < 2) begin
                run_one_file(s == NUM_STEPS - 1);
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);

        $display("Streamed %0d items in %0d files under %0d chunk limit settings.",
                 items_sent, files_sent, limits_used);
        $display("Checked %0d results: %0d parsed headers, %0d failed parses.",
                 board.results_seen, board.headers_ok,
                 board.results_seen - board.headers_ok);
        if (board.total_failures() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results still expected",
                     board.mismatches, board.pending());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
